@@ design/sv39m_pkg.sv @@
// shared types and constants of the page table mapper
`timescale 1ns / 1ps

package sv39m_pkg;

  localparam int unsigned VaddrW  = 39;
  localparam int unsigned OffsetW = 12;
  localparam int unsigned VpnW    = 27;
  localparam int unsigned PpnW    = 44;
  localparam int unsigned IdxW    = 9;
  localparam int unsigned PermW   = 3;
  localparam int unsigned CountW  = 7;
  localparam int unsigned StatusW = 2;

  localparam logic OP_MAP    = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_MAPPED   = 2'd1,
    ST_UNMAPPED = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD2,
    S_CHK2,
    S_RD1,
    S_CHK1,
    S_RD0,
    S_CHK0,
    S_FIN
  } walk_state_e;

  // table entry as kept in the store; the always-zero bits are not stored
  typedef struct packed {
    logic [PpnW-1:0]  page;
    logic [PermW-1:0] perm;
    logic             valid;
  } entry_t;

endpackage

@@ design/sv39m_store.sv @@
// table store: one write port, one registered read port, cleared after reset
`timescale 1ns / 1ps

module sv39m_store
  import sv39m_pkg::*;
#(
  parameter int unsigned DEPTH  = 32768,
  parameter int unsigned ADDR_W = 15
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output entry_t            rd_data_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  entry_t            wr_data_i,
  output logic              ready_o
);

  entry_t mem [DEPTH];
  entry_t rd_data_q;

  logic              clearing_q, clearing_d;
  logic [ADDR_W-1:0] clr_q, clr_d;

  logic              we;
  logic [ADDR_W-1:0] wa;
  entry_t            wd;

  always_comb begin
    clearing_d = clearing_q;
    clr_d      = clr_q;
    if (clearing_q) begin
      clr_d = ADDR_W'(clr_q + 1'b1);
      if (clr_q == ADDR_W'(DEPTH - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_comb begin
    if (clearing_q) begin
      we = 1'b1;
      wa = clr_q;
      wd = '0;
    end else begin
      we = wr_en_i;
      wa = wr_addr_i;
      wd = wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_q      <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign ready_o   = !clearing_q;

endmodule

@@ design/sv39_page_table_mapper_unit.sv @@
// page table mapper top level: walk sequencer around the table store
`timescale 1ns / 1ps

// Three-level page table mapper. An input item is a map of a run of
// consecutive pages or a lookup of one address; every item gives exactly
// one result item on the output channel. Both channels are valid/ready.
// After reset the table store is swept to zero, one entry per cycle, over
// all TABLE_PAGES*512 entries; no item is accepted until the sweep ends.
// A walk reads each level in a read state (address), then a check state on
// the registered read data, so each page costs three dependent reads
// of the single read port of the store. A map stops early on an error;
// a map of zero pages goes straight to the final state and reads nothing.
// The result sits in an output register; when the receiver stalls, the
// sequencer holds in its final state until that register is free, and a
// new item is accepted only once the sequencer is back to idle.
module sv39_page_table_mapper_unit
  import sv39m_pkg::*;
#(
  parameter int unsigned TABLE_PAGES = 64,
  parameter int unsigned MAX_RUN     = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  opcode_i,
  input  logic [VaddrW-1:0]     virt_addr_i,
  input  logic [PpnW-1:0]       phys_page_i,
  input  logic [CountW-1:0]     page_count_i,
  input  logic [PermW-1:0]      permissions_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [StatusW-1:0]    status_o,
  output logic [CountW-1:0]     pages_done_o,
  output logic [PpnW-1:0]       found_phys_page_o,
  output logic [PermW-1:0]      found_permissions_o
);

  localparam int unsigned DEPTH  = TABLE_PAGES * 512;
  localparam int unsigned PG_W   = $clog2(TABLE_PAGES);
  localparam int unsigned ADDR_W = PG_W + IdxW;
  localparam int unsigned NF_W   = $clog2(TABLE_PAGES + 1);
  localparam int unsigned RunCap = (MAX_RUN > 127) ? 127 : MAX_RUN;

  walk_state_e state_q, state_d;

  logic              op_q, op_d;
  logic [VpnW-1:0]   vpn_q, vpn_d;
  logic [PpnW-1:0]   ppn_q, ppn_d;
  logic [PermW-1:0]  perm_q, perm_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] done_q, done_d;
  logic [PG_W-1:0]   page_q, page_d;
  logic [NF_W-1:0]   next_free_q, next_free_d;
  status_e           res_status_q, res_status_d;
  logic [PpnW-1:0]   res_phys_q, res_phys_d;
  logic [PermW-1:0]  res_perm_q, res_perm_d;

  logic              out_valid_q, out_valid_d;
  status_e           out_status_q, out_status_d;
  logic [CountW-1:0] out_done_q, out_done_d;
  logic [PpnW-1:0]   out_phys_q, out_phys_d;
  logic [PermW-1:0]  out_perm_q, out_perm_d;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  entry_t            rd_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            wr_data;
  logic              store_ready;

  logic              accept;
  logic [CountW-1:0] count_in;
  logic [IdxW-1:0]   idx2, idx1, idx0;
  logic [ADDR_W-1:0] addr2, addr1, addr0;
  logic              ent_bad;
  logic              pool_empty;
  logic              mid_fail;
  status_e           mid_status;
  logic              mid_alloc;
  logic              leaf_last;
  logic              out_free;

  sv39m_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .ready_o   (store_ready)
  );

  assign in_ready_o = (state_q == S_IDLE) && store_ready;
  assign accept     = in_valid_i && in_ready_o;
  assign count_in   = (page_count_i > CountW'(RunCap)) ? CountW'(RunCap) : page_count_i;
  assign out_free   = !out_valid_q || out_ready_i;

  assign idx2  = vpn_q[3*IdxW-1:2*IdxW];
  assign idx1  = vpn_q[2*IdxW-1:IdxW];
  assign idx0  = vpn_q[IdxW-1:0];
  assign addr2 = {PG_W'(0), idx2};
  assign addr1 = {page_q, idx1};
  assign addr0 = {page_q, idx0};

  // intermediate level decision on the entry just read
  assign ent_bad    = rd_data.page >= PpnW'(TABLE_PAGES);
  assign pool_empty = next_free_q >= NF_W'(TABLE_PAGES);
  always_comb begin
    mid_fail   = 1'b0;
    mid_status = ST_OK;
    mid_alloc  = 1'b0;
    if (rd_data.valid) begin
      if (ent_bad) begin
        mid_fail   = 1'b1;
        mid_status = (op_q == OP_MAP) ? ST_MAPPED : ST_UNMAPPED;
      end
    end else if (op_q == OP_LOOKUP) begin
      mid_fail   = 1'b1;
      mid_status = ST_UNMAPPED;
    end else if (pool_empty) begin
      mid_fail   = 1'b1;
      mid_status = ST_FULL;
    end else begin
      mid_alloc = 1'b1;
    end
  end

  assign leaf_last = CountW'(done_q + 1'b1) == count_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (opcode_i == OP_MAP && count_in == '0) ? S_FIN : S_RD2;
        end
      end
      S_RD2:  state_d = S_CHK2;
      S_CHK2: state_d = mid_fail ? S_FIN : S_RD1;
      S_RD1:  state_d = S_CHK1;
      S_CHK1: state_d = mid_fail ? S_FIN : S_RD0;
      S_RD0:  state_d = S_CHK0;
      S_CHK0: begin
        if (op_q == OP_LOOKUP || rd_data.valid || leaf_last) begin
          state_d = S_FIN;
        end else begin
          state_d = S_RD2;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and store controls
  always_comb begin
    op_d         = op_q;
    vpn_d        = vpn_q;
    ppn_d        = ppn_q;
    perm_d       = perm_q;
    count_d      = count_q;
    done_d       = done_q;
    page_d       = page_q;
    next_free_d  = next_free_q;
    res_status_d = res_status_q;
    res_phys_d   = res_phys_q;
    res_perm_d   = res_perm_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_done_d   = out_done_q;
    out_phys_d   = out_phys_q;
    out_perm_d   = out_perm_q;
    rd_en        = 1'b0;
    rd_addr      = addr2;
    wr_en        = 1'b0;
    wr_addr      = addr0;
    wr_data      = '0;
    unique case (state_q) inside
      S_IDLE: begin
        if (accept) begin
          op_d         = opcode_i;
          vpn_d        = virt_addr_i[VaddrW-1:OffsetW];
          ppn_d        = phys_page_i;
          perm_d       = permissions_i;
          count_d      = count_in;
          done_d       = '0;
          page_d       = '0;
          res_status_d = ST_OK;
          res_phys_d   = '0;
          res_perm_d   = '0;
        end
      end
      S_RD2: begin
        rd_en   = 1'b1;
        rd_addr = addr2;
      end
      S_RD1: begin
        rd_en   = 1'b1;
        rd_addr = addr1;
      end
      S_RD0: begin
        rd_en   = 1'b1;
        rd_addr = addr0;
      end
      S_CHK2, S_CHK1: begin
        if (mid_fail) begin
          res_status_d = mid_status;
        end else if (mid_alloc) begin
          // hand out a fresh table page and link it in
          wr_en        = 1'b1;
          wr_addr      = (state_q == S_CHK2) ? addr2 : addr1;
          wr_data      = '{page: PpnW'(next_free_q), perm: '0, valid: 1'b1};
          page_d       = next_free_q[PG_W-1:0];
          next_free_d  = NF_W'(next_free_q + 1'b1);
        end else begin
          page_d = rd_data.page[PG_W-1:0];
        end
      end
      S_CHK0: begin
        if (op_q == OP_LOOKUP) begin
          if (rd_data.valid) begin
            res_phys_d = rd_data.page;
            res_perm_d = rd_data.perm;
          end else begin
            res_status_d = ST_UNMAPPED;
          end
        end else if (rd_data.valid) begin
          res_status_d = ST_MAPPED;
        end else begin
          wr_en   = 1'b1;
          wr_addr = addr0;
          wr_data = '{page: ppn_q, perm: perm_q, valid: 1'b1};
          done_d  = CountW'(done_q + 1'b1);
          vpn_d   = VpnW'(vpn_q + 1'b1);
          ppn_d   = PpnW'(ppn_q + 1'b1);
          page_d  = '0;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_done_d   = done_q;
          out_phys_d   = res_phys_q;
          out_perm_d   = res_perm_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      next_free_q <= NF_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_free_q <= next_free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    vpn_q        <= vpn_d;
    ppn_q        <= ppn_d;
    perm_q       <= perm_d;
    count_q      <= count_d;
    done_q       <= done_d;
    page_q       <= page_d;
    res_status_q <= res_status_d;
    res_phys_q   <= res_phys_d;
    res_perm_q   <= res_perm_d;
    out_status_q <= out_status_d;
    out_done_q   <= out_done_d;
    out_phys_q   <= out_phys_d;
    out_perm_q   <= out_perm_d;
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = out_status_q;
  assign pages_done_o        = out_done_q;
  assign found_phys_page_o   = out_phys_q;
  assign found_permissions_o = out_perm_q;

endmodule

@@ dv/testbench.sv @@
// self-checking testbench of the sv39 page table mapper unit
`timescale 1ns / 1ps

module testbench;
  import sv39m_pkg::*;

  localparam int unsigned TablePages     = 64;
  localparam int unsigned MaxRun         = 64;
  localparam int unsigned EntriesPerPage = 512;
  localparam int unsigned IdxMask        = 'h1FF;
  localparam int unsigned CycleLimit     = 2_000_000;
  localparam int unsigned DrainCycles    = 400;
  localparam int unsigned HoldCycles     = 1500;
  localparam int unsigned RandomHalf     = 340;
  localparam int unsigned RegionCount    = 8;

  typedef struct packed {
    logic              opcode;
    logic [VaddrW-1:0] virt_addr;
    logic [PpnW-1:0]   phys_page;
    logic [CountW-1:0] page_count;
    logic [PermW-1:0]  permissions;
  } pt_req_t;

  typedef struct packed {
    status_e           status;
    logic [CountW-1:0] pages_done;
    logic [PpnW-1:0]   phys_page;
    logic [PermW-1:0]  perm;
  } pt_resp_t;

  logic                clk_i;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic                opcode_i       = OP_MAP;
  logic [VaddrW-1:0]   virt_addr_i    = '0;
  logic [PpnW-1:0]     phys_page_i    = '0;
  logic [CountW-1:0]   page_count_i   = '0;
  logic [PermW-1:0]    permissions_i  = '0;
  logic                out_valid_o;
  logic                out_ready_i    = 1'b0;
  logic [StatusW-1:0]  status_o;
  logic [CountW-1:0]   pages_done_o;
  logic [PpnW-1:0]     found_phys_page_o;
  logic [PermW-1:0]    found_permissions_o;

  // shadow of the table store and the table page allocator
  entry_t      shadow_tbl [int unsigned];
  int unsigned next_tbl_page = 1;

  pt_req_t         pending_req_q [$];
  pt_resp_t        expected_resp_q [$];
  logic [VpnW-1:0] map_starts [$];
  logic [17:0]     region_pool [RegionCount];

  logic        req_taken    = 1'b0;
  int unsigned accepted_cnt = 0;
  int unsigned resp_cnt     = 0;
  int unsigned err_cnt      = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;

  sv39_page_table_mapper_unit #(
    .TABLE_PAGES(TablePages),
    .MAX_RUN    (MaxRun)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .opcode_i           (opcode_i),
    .virt_addr_i        (virt_addr_i),
    .phys_page_i        (phys_page_i),
    .page_count_i       (page_count_i),
    .permissions_i      (permissions_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .pages_done_o       (pages_done_o),
    .found_phys_page_o  (found_phys_page_o),
    .found_permissions_o(found_permissions_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic entry_t shadow_read(int unsigned addr);
    if (shadow_tbl.exists(addr)) begin
      return shadow_tbl[addr];
    end
    return '0;
  endfunction

  // walks levels 2 and 1, optionally allocating; slot is the leaf address
  function automatic status_e walk_tables(logic [VpnW-1:0] vpn, bit alloc,
                                          output int unsigned slot);
    int unsigned pg;
    int unsigned addr;
    entry_t      ent;
    pg   = 0;
    slot = 0;
    for (int lvl = 2; lvl > 0; lvl--) begin
      addr = pg * EntriesPerPage + ((vpn >> (IdxW * lvl)) & IdxMask);
      ent  = shadow_read(addr);
      if (ent.valid) begin
        // pointer past the store: cannot happen, handled anyway
        if (ent.page >= TablePages) begin
          if (alloc) begin
            return ST_MAPPED;
          end
          return ST_UNMAPPED;
        end
        pg = 32'(ent.page);
      end else begin
        if (!alloc) begin
          return ST_UNMAPPED;
        end
        if (next_tbl_page >= TablePages) begin
          return ST_FULL;
        end
        pg = next_tbl_page;
        next_tbl_page++;
        shadow_tbl[addr] = '{page: PpnW'(pg), perm: '0, valid: 1'b1};
      end
    end
    slot = pg * EntriesPerPage + (vpn & IdxMask);
    return ST_OK;
  endfunction

  function automatic pt_resp_t apply_request(pt_req_t req);
    pt_resp_t        resp;
    logic [VpnW-1:0] vpn;
    logic [PpnW-1:0] ppn;
    int unsigned     run_len;
    int unsigned     slot;
    status_e         st;
    entry_t          leaf;
    resp = '0;
    vpn  = req.virt_addr[VaddrW-1:OffsetW];
    ppn  = req.phys_page;
    if (req.opcode == OP_LOOKUP) begin
      st = walk_tables(vpn, 1'b0, slot);
      leaf = shadow_read(slot);
      if (st == ST_OK && leaf.valid) begin
        resp.phys_page = leaf.page;
        resp.perm      = leaf.perm;
      end else begin
        resp.status = ST_UNMAPPED;
      end
    end else begin
      run_len = (req.page_count > MaxRun) ? MaxRun : req.page_count;
      for (int unsigned i = 0; i < run_len; i++) begin
        st = walk_tables(vpn, 1'b1, slot);
        if (st == ST_OK) begin
          leaf = shadow_read(slot);
          if (leaf.valid) begin
            st = ST_MAPPED;
          end
        end
        if (st != ST_OK) begin
          resp.status = st;
          break;
        end
        shadow_tbl[slot] = '{page: ppn, perm: req.permissions, valid: 1'b1};
        resp.pages_done++;
        // both page numbers wrap at their own widths
        vpn++;
        ppn++;
      end
    end
    return resp;
  endfunction

  task automatic push_req(logic op, logic [VpnW-1:0] vpn, logic [OffsetW-1:0] offs,
                          logic [PpnW-1:0] ppn, logic [CountW-1:0] cnt,
                          logic [PermW-1:0] perm);
    pending_req_q.push_back('{opcode: op, virt_addr: {vpn, offs}, phys_page: ppn,
                              page_count: cnt, permissions: perm});
    if (op == OP_MAP) begin
      map_starts.push_back(vpn);
      if (map_starts.size() > 64) begin
        void'(map_starts.pop_front());
      end
    end
  endtask

  function automatic logic [CountW-1:0] pick_count();
    int unsigned w;
    w = $urandom_range(99);
    if (w < 60) return CountW'($urandom_range(8, 1));
    if (w < 85) return CountW'($urandom_range(24, 9));
    if (w < 95) return CountW'($urandom_range(64, 25));
    if (w < 98) return CountW'($urandom_range(127, 65));
    return '0;
  endfunction

  // mostly runs and lookups inside a few regions so tables get reused;
  // noise items hit arbitrary addresses and drain the table pages
  task automatic push_random(bit with_noise);
    logic              op;
    logic [VpnW-1:0]   vpn;
    logic [OffsetW-1:0] offs;
    logic [PpnW-1:0]   ppn;
    logic [PermW-1:0]  perm;
    offs = OffsetW'($urandom);
    ppn  = PpnW'({$urandom, $urandom});
    perm = PermW'($urandom);
    if (with_noise && $urandom_range(99) < 20) begin
      op  = $urandom_range(1) ? OP_LOOKUP : OP_MAP;
      vpn = VpnW'($urandom);
      push_req(op, vpn, offs, ppn, CountW'($urandom_range(127)), perm);
    end else begin
      op  = ($urandom_range(99) < 40) ? OP_LOOKUP : OP_MAP;
      vpn = {region_pool[$urandom_range(RegionCount - 1)], 9'($urandom)};
      if (op == OP_LOOKUP && map_starts.size() != 0 && $urandom_range(1)) begin
        vpn = VpnW'(map_starts[$urandom_range(map_starts.size() - 1)] +
                    $urandom_range(3));
      end
      push_req(op, vpn, offs, ppn, pick_count(), perm);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin : stimulus
    logic [8:0] l2_pick [3];
    l2_pick[0] = 9'd0;
    l2_pick[1] = 9'd511;
    l2_pick[2] = 9'($urandom);
    for (int k = 0; k < RegionCount; k++) begin
      region_pool[k] = {l2_pick[k % 3], 9'($urandom)};
    end

    // lookup with no tables at all, empty run, single page and its lookup
    push_req(OP_LOOKUP, 27'd0, 12'h000, '0, 7'd1, 3'd0);
    push_req(OP_MAP, 27'd0, 12'h000, 44'd5, 7'd0, 3'd7);
    push_req(OP_MAP, 27'd0, 12'h000, 44'd0, 7'd1, 3'd0);
    push_req(OP_LOOKUP, 27'd0, 12'hFFF, '1, 7'd0, 3'd7);
    // leaf table exists but the leaf does not
    push_req(OP_LOOKUP, 27'd1, 12'h000, '0, 7'd1, 3'd0);
    push_req(OP_MAP, 27'd0, 12'h123, 44'd9, 7'd3, 3'd7);
    // physical page wraps to zero
    push_req(OP_MAP, 27'd1, 12'h000, '1, 7'd2, 3'd7);
    push_req(OP_LOOKUP, 27'd1, 12'h000, '0, 7'd0, 3'd0);
    push_req(OP_LOOKUP, 27'd2, 12'h000, '0, 7'd0, 3'd0);
    // virtual page wraps into the already mapped page zero
    push_req(OP_MAP, '1 - 27'd1, 12'h000, 44'd123, 7'd4, 3'd5);
    push_req(OP_LOOKUP, '1, 12'hFFF, '0, 7'd0, 3'd0);
    // oversized count saturates, run crosses a leaf table boundary
    push_req(OP_MAP, 27'(5 * 512 + 480), 12'h000, 44'h800_0000_0000, 7'd127, 3'd6);
    push_req(OP_LOOKUP, 27'(5 * 512 + 480 + 63), 12'h000, '0, 7'd0, 3'd0);
    push_req(OP_LOOKUP, 27'(5 * 512 + 480 + 64), 12'h000, '0, 7'd0, 3'd0);
    push_req(OP_MAP, {9'd1, 9'd511, 9'd400}, 12'hFFF, 44'h5555_5555_555, 7'd64, 3'd3);
    push_req(OP_LOOKUP, {9'd1, 9'd511, 9'd463}, 12'h800, '0, 7'd0, 3'd0);
    for (int p = 1; p < 8; p = p * 2) begin
      push_req(OP_MAP, 27'(2 + p), 12'h000, 44'(1000 + p), 7'd1, PermW'(p));
    end
    push_req(OP_MAP, 27'd6, 12'h000, 44'd77, 7'd1, 3'd6);
    push_req(OP_LOOKUP, 27'd6, 12'h000, '0, 7'd0, 3'd0);
    push_req(OP_MAP, {9'd2, 9'd0, 9'd0}, 12'h000, 44'hAAA_AAAA_AAAA, 7'd65, 3'd1);

    for (int i = 0; i < RandomHalf; i++) begin
      push_random(1'b0);
    end
    for (int i = 0; i < RandomHalf; i++) begin
      push_random(1'b1);
    end

    while (pending_req_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_resp_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("sv39_page_table_mapper_unit verification clean");
    end else begin
      $display("sv39_page_table_mapper_unit verification failed");
    end
    $finish;
  end

  // request side: new item only once the current one is taken
  always @(negedge clk_i) begin : req_drive
    pt_req_t nxt;
    bit      quiet;
    quiet = (accepted_cnt >= 250 && accepted_cnt < 400);
    if (rst_ni && (!in_valid_i || req_taken)) begin
      if (pending_req_q.size() != 0 && (quiet || $urandom_range(99) >= 20)) begin
        nxt = pending_req_q.pop_front();
        in_valid_i    <= 1'b1;
        opcode_i      <= nxt.opcode;
        virt_addr_i   <= nxt.virt_addr;
        phys_page_i   <= nxt.phys_page;
        page_count_i  <= nxt.page_count;
        permissions_i <= nxt.permissions;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result side: random stalls plus one long hold-off
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (!hold_done && resp_cnt >= 120) begin
      hold_left   <= HoldCycles;
      hold_done   <= 1'b1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= (resp_cnt >= 250 && resp_cnt < 400) || ($urandom_range(99) >= 20);
    end
  end

  always @(posedge clk_i) begin : observe
    pt_resp_t want;
    req_taken <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o) begin
      expected_resp_q.push_back(apply_request({opcode_i, virt_addr_i, phys_page_i,
                                               page_count_i, permissions_i}));
      accepted_cnt++;
    end
    if (out_valid_o && out_ready_i) begin
      resp_cnt++;
      if (expected_resp_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) begin
          $display("unexpected result item: status %0d done %0d phys %h perm %0d",
                   status_o, pages_done_o, found_phys_page_o, found_permissions_o);
        end
      end else begin
        want = expected_resp_q.pop_front();
        if (status_o !== want.status || pages_done_o !== want.pages_done ||
            found_phys_page_o !== want.phys_page || found_permissions_o !== want.perm) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("result %0d mismatch: exp status %0d done %0d phys %h perm %0d",
                     resp_cnt, want.status, want.pages_done, want.phys_page, want.perm);
            $display("                     got status %0d done %0d phys %h perm %0d",
                     status_o, pages_done_o, found_phys_page_o, found_permissions_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("sv39_page_table_mapper_unit verification failed");
      $finish;
    end
  end

endmodule
